/* hdl/cxu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxu_pkg
// Types, register indexes and block-function helpers shared by the
// ChaCha20 keystream XOR unit.
// ----------------------------------------------------------------------------
package cxu_pkg;

  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 8 * WORD_BYTES;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WPOS_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CTR = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA [4] = '{
    32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
  };

  typedef struct packed {
    logic [WORD_W-1:0] data_in;
    logic [CNT_W-1:0]  byte_count;
    logic              last_word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]  byte_count_out;
    logic              last_out;
  } out_word_t;

  typedef struct packed {
    logic              latch_in;
    logic              load_ctr;
    logic              load_x;
    logic              do_round;
    logic              diag;
    logic              feed;
    logic              emit;
    logic              inc_ctr;
    logic [WPOS_W-1:0] wpos;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

  function automatic qr_t quarter_round(input qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl32(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl32(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl32(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl32(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

/* hdl/cxu_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxu_in_if / cxu_out_if
// Valid/ready channels carrying message words into and out of the unit.
// ----------------------------------------------------------------------------
interface cxu_in_if;
  import cxu_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface cxu_out_if;
  import cxu_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* hdl/chacha20_keystream_xor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_unit
// XORs 8-byte message words with the ChaCha20 (IETF) keystream.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------
//   in_ch    | in  | valid/ready        | data_in, byte_count, last_word
//   out_ch   | out | valid/ready        | data_out, byte_count_out, last_out
//   cfg_*    | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// A word that needs a new keystream block passes through one load, the
// column and diagonal rounds on four shared quarter-round lanes, one
// feed-forward add and one emit. Other words go straight from the input to
// the emit. The input is taken again once the word sits in the output
// register; a stalled output holds the emit stage. Synchronous reset clears
// control and configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_unit #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cxu_in_if.sink                         in_ch,
  cxu_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cxu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cxu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cxu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cxu_ctrl #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  cxu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_ch.word),
    .cmd       (cmd),
    .status    (status),
    .out_word  (out_ch.word)
  );

endmodule

/* hdl/cxu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxu_datapath
// Configuration registers, block counter, 16-word working state with four
// quarter-round lanes, feed-forward add and the output XOR/mask register.
// ----------------------------------------------------------------------------
module cxu_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cxu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cxu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  cxu_pkg::in_word_t              in_word,
  input  cxu_pkg::dp_cmd_t               cmd,
  output cxu_pkg::dp_status_t            status,
  output cxu_pkg::out_word_t             out_word
);
  import cxu_pkg::*;

  logic [63:0]       key_r [4];
  logic [63:0]       nonce_lo_r;
  logic [31:0]       nonce_hi_r;
  logic [31:0]       start_ctr_r;
  logic [31:0]       ctr_r;
  logic [31:0]       x_r [16];
  logic [31:0]       x_nxt [16];
  logic [31:0]       init_w [16];
  logic [31:0]       rnd_x [16];
  in_word_t          in_r;
  out_word_t         out_r;
  out_word_t         out_nxt;
  logic [WORD_W-1:0] ks_word;
  logic [CNT_W-1:0]  cnt_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_ctr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0:      key_r[0]    <= cfg_data;
        CFG_KEY1:      key_r[1]    <= cfg_data;
        CFG_KEY2:      key_r[2]    <= cfg_data;
        CFG_KEY3:      key_r[3]    <= cfg_data;
        CFG_NONCE_LO:  nonce_lo_r  <= cfg_data;
        CFG_NONCE_HI:  nonce_hi_r  <= cfg_data[31:0];
        CFG_START_CTR: start_ctr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // block function input words
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = SIGMA[i];
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = ctr_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // one column or diagonal round: four independent lanes
  always_comb begin
    qr_t q_in;
    qr_t q_out;
    for (int i = 0; i < 16; i++) rnd_x[i] = x_r[i];
    for (int i = 0; i < 4; i++) begin
      if (cmd.diag) begin
        q_in.a = x_r[i];
        q_in.b = x_r[4 + ((i + 1) % 4)];
        q_in.c = x_r[8 + ((i + 2) % 4)];
        q_in.d = x_r[12 + ((i + 3) % 4)];
      end else begin
        q_in.a = x_r[i];
        q_in.b = x_r[4 + i];
        q_in.c = x_r[8 + i];
        q_in.d = x_r[12 + i];
      end
      q_out = quarter_round(q_in);
      if (cmd.diag) begin
        rnd_x[i]                  = q_out.a;
        rnd_x[4 + ((i + 1) % 4)]  = q_out.b;
        rnd_x[8 + ((i + 2) % 4)]  = q_out.c;
        rnd_x[12 + ((i + 3) % 4)] = q_out.d;
      end else begin
        rnd_x[i]      = q_out.a;
        rnd_x[4 + i]  = q_out.b;
        rnd_x[8 + i]  = q_out.c;
        rnd_x[12 + i] = q_out.d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (cmd.load_x) begin
        x_nxt[i] = init_w[i];
      end else if (cmd.do_round) begin
        x_nxt[i] = rnd_x[i];
      end else if (cmd.feed) begin
        x_nxt[i] = x_r[i] + init_w[i];
      end else begin
        x_nxt[i] = x_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) x_r[i] <= x_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.load_ctr) begin
      ctr_r <= start_ctr_r;
    end else if (cmd.inc_ctr) begin
      ctr_r <= ctr_r + 32'd1;
    end
  end

  // keystream word and lane mask
  assign ks_word = {x_r[{cmd.wpos, 1'b1}], x_r[{cmd.wpos, 1'b0}]};
  assign cnt_sat = (in_r.byte_count > CNT_W'(WORD_BYTES)) ? CNT_W'(WORD_BYTES)
                                                          : in_r.byte_count;

  always_comb begin
    out_nxt = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (CNT_W'(i) < cnt_sat) begin
        out_nxt.data_out[8*i +: 8] = in_r.data_in[8*i +: 8] ^ ks_word[8*i +: 8];
      end
    end
    out_nxt.byte_count_out = cnt_sat;
    out_nxt.last_out       = in_r.last_word;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_word;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign status.last_word = in_r.last_word;
  assign out_word         = out_r;

endmodule

/* hdl/cxu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxu_ctrl
// Sequencer: input/output handshakes, message and block tracking, round
// counting and datapath commands.
// ----------------------------------------------------------------------------
module cxu_ctrl #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cxu_pkg::dp_cmd_t     cmd,
  input  cxu_pkg::dp_status_t  status
);
  import cxu_pkg::*;

  localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(2 * DOUBLE_ROUNDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FEED,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic              ks_ready_r, ks_ready_nxt;
  logic [WPOS_W-1:0] wpos_r, wpos_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              in_fire;
  logic              emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_msg_nxt    = in_msg_r;
    ks_ready_nxt  = ks_ready_r;
    wpos_nxt      = wpos_r;
    rnd_nxt       = rnd_r;
    cmd           = '0;
    cmd.wpos      = wpos_r;
    cmd.diag      = rnd_r[0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch_in = 1'b1;
          if (!in_msg_r) begin
            // message start: reload the counter, rewind the block
            cmd.load_ctr = 1'b1;
            in_msg_nxt   = 1'b1;
            ks_ready_nxt = 1'b0;
            wpos_nxt     = '0;
            state_nxt    = S_LOAD;
          end else if (!ks_ready_r) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_LOAD: begin
        cmd.load_x = 1'b1;
        rnd_nxt    = '0;
        state_nxt  = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        rnd_nxt      = rnd_r + RND_W'(1);
        if (rnd_r == RND_LAST) begin
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        cmd.feed     = 1'b1;
        ks_ready_nxt = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          wpos_nxt      = wpos_r + WPOS_W'(1);
          if (wpos_r == {WPOS_W{1'b1}}) begin
            // block used up: advance the counter
            cmd.inc_ctr  = 1'b1;
            ks_ready_nxt = 1'b0;
          end
          if (status.last_word) begin
            // drop the rest of the block
            in_msg_nxt   = 1'b0;
            ks_ready_nxt = 1'b0;
            wpos_nxt     = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_msg_r    <= 1'b0;
      ks_ready_r  <= 1'b0;
      wpos_r      <= '0;
      rnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      in_msg_r    <= in_msg_nxt;
      ks_ready_r  <= ks_ready_nxt;
      wpos_r      <= wpos_nxt;
      rnd_r       <= rnd_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_loads_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_msg_r |=> state_r == S_LOAD)
    else $error("message start did not compute a fresh block");

  a_rounds_then_feed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == RND_LAST |=> state_r == S_FEED)
    else $error("final round not followed by feed-forward");

  a_emit_has_keystream: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> ks_ready_r && in_msg_r)
    else $error("emit without a valid keystream block");

  a_pending_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_valid_r && !out_ready |=> state_r == S_EMIT)
    else $error("emit overwrote an untaken output word");
`endif

endmodule
